/* sv/lcom_pkg.sv */
// Shared types and constants for the lidar curvature / occlusion marker.
// No dependencies.
package lcom_pkg;

  localparam int unsigned COORD_W   = 18;
  localparam int unsigned COL_W     = 12;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned CURV_W    = 47;
  localparam int unsigned WEIGHT_W  = 17;
  localparam int unsigned GAP_W     = 16;
  localparam int unsigned COL_LIMIT = 10;
  localparam int unsigned PAR_RATIO = 50;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 17'h10000;
  localparam logic [GAP_W-1:0]    GAP_RST    = 16'd307;

  // register indexes on the config port
  localparam logic REG_RANGE_WEIGHT  = 1'b0;
  localparam logic REG_OCCLUSION_GAP = 1'b1;

  typedef enum logic {
    FE_IDLE,
    FE_EMIT
  } fe_state_t;

  // handshake between front end and queue
  typedef struct packed {
    logic push;
  } q_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* sv/lcom_fifo.sv */
// Short queue of emit records between front end and curvature pipe.
// Depends on lcom_pkg.
module lcom_fifo #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lcom_pkg::q_wr_t   wr,
  input  logic [DW-1:0]     wdata,
  input  logic              pop,
  output logic [DW-1:0]     rdata,
  output lcom_pkg::q_stat_t stat
);
  localparam int unsigned AW = $clog2(DEPTH);

  logic [DW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign stat.full  = (cnt_r == (AW+1)'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = wr.push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !wr.push) else $error("push into full queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH)) else $error("queue count out of range");
  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("queue count did not drop on pop");
endmodule

/* sv/lcom_front.sv */
// Front end: point window, occlusion / parallel-beam marking, emit sequencer.
// Depends on lcom_pkg.
module lcom_front #(
  parameter int unsigned HALF_WINDOW = 5,
  parameter int unsigned MAX_POINTS  = 65536,
  parameter int unsigned SW          = 24,
  parameter int unsigned RW          = 115
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [17:0]                  in_range,
  input  logic signed [17:0]           in_x,
  input  logic signed [17:0]           in_y,
  input  logic signed [17:0]           in_z,
  input  logic [11:0]                  in_col,
  input  logic                         in_last,
  input  logic [15:0]                  gap,
  output lcom_pkg::q_wr_t              q_wr,
  output logic [RW-1:0]                q_data,
  input  lcom_pkg::q_stat_t            q_stat
);
  localparam int unsigned H   = HALF_WINDOW;
  localparam int unsigned WIN = 2*H + 2;
  localparam int unsigned PW  = $clog2(MAX_POINTS);
  localparam int unsigned SLW = $clog2(WIN) + 1;
  localparam int unsigned FW  = $clog2(H + 1);

  logic [17:0]        rng_r [WIN];
  logic signed [17:0] x_r   [WIN];
  logic signed [17:0] y_r   [WIN];
  logic signed [17:0] z_r   [WIN];
  logic [11:0]        col_r [WIN];
  logic [WIN-1:0]     flg_r, flg_nxt;
  logic [PW-1:0]      cnt_r;
  logic [FW-1:0]      fwd_r, fwd_nxt;
  logic [PW-1:0]      p_r;
  logic               last_r;
  logic [SLW-1:0]     slot_r, slot_nxt, send_r, s_start, s_end;
  lcom_pkg::fe_state_t state_r, state_nxt;

  logic        acc, clr, last_in, push, done;
  logic [19:0] ra_e, rb_e;
  logic [12:0] cd;
  logic [17:0] d1, d2;
  logic [PW:0] idx_w;
  logic [PW+15:0] idx_ext;
  logic        rec_valid, rec_last;
  logic signed [SW-1:0] dr, dx, dy, dz;

  assign in_ready = (state_r == lcom_pkg::FE_IDLE);
  assign acc      = in_valid && in_ready;
  assign last_in  = in_last || (cnt_r == PW'(MAX_POINTS - 1));

  // marking on the shifted window: a = old tail, b = new point
  always_comb begin
    flg_nxt = {fwd_r != '0, flg_r[WIN-1:1]};
    fwd_nxt = (fwd_r != '0) ? fwd_r - 1'b1 : fwd_r;
    ra_e    = {2'b0, rng_r[WIN-1]};
    rb_e    = {2'b0, in_range};
    cd      = (in_col >= col_r[WIN-1]) ? 13'(in_col - col_r[WIN-1])
                                       : 13'(col_r[WIN-1] - in_col);
    d1      = (rng_r[WIN-2] >= rng_r[WIN-1]) ? rng_r[WIN-2] - rng_r[WIN-1]
                                             : rng_r[WIN-1] - rng_r[WIN-2];
    d2      = (in_range >= rng_r[WIN-1]) ? in_range - rng_r[WIN-1]
                                         : rng_r[WIN-1] - in_range;
    if (cnt_r >= PW'(H + 1)) begin
      if (cd < 13'(lcom_pkg::COL_LIMIT)) begin
        if (ra_e > rb_e + 20'(gap)) begin
          for (int s = WIN - 2 - H; s <= WIN - 2; s++) flg_nxt[s] = 1'b1;
        end else if (rb_e > ra_e + 20'(gap)) begin
          flg_nxt[WIN-1] = 1'b1;
          fwd_nxt        = FW'(H);
        end
      end
      if ((24'(d1) * 24'(lcom_pkg::PAR_RATIO) > 24'(rng_r[WIN-1])) &&
          (24'(d2) * 24'(lcom_pkg::PAR_RATIO) > 24'(rng_r[WIN-1]))) begin
        flg_nxt[WIN-2] = 1'b1;
      end
    end
  end

  always_comb begin
    s_start = (cnt_r < PW'(WIN - 1)) ? SLW'(PW'(WIN - 1) - cnt_r) : SLW'(H);
    if (s_start < SLW'(H)) s_start = SLW'(H);
    s_end   = last_in ? SLW'(WIN - 1) : SLW'(H);
  end

  // emit sequencer
  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    push      = 1'b0;
    clr       = 1'b0;
    done      = (slot_r == send_r);
    case (state_r)
      lcom_pkg::FE_IDLE: begin
        if (acc && s_start <= s_end) begin
          state_nxt = lcom_pkg::FE_EMIT;
          slot_nxt  = s_start;
        end
      end
      lcom_pkg::FE_EMIT: begin
        if (!q_stat.full) begin
          push = 1'b1;
          if (done) begin
            state_nxt = lcom_pkg::FE_IDLE;
            clr       = last_r;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end
      end
      default: state_nxt = lcom_pkg::FE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcom_pkg::FE_IDLE;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p_r    <= cnt_r;
      last_r <= last_in;
      send_r <= s_end;
    end
  end

  // window and scan state; a flush returns it to reset
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      for (int s = 0; s < WIN; s++) begin
        rng_r[s] <= '0;
        x_r[s]   <= '0;
        y_r[s]   <= '0;
        z_r[s]   <= '0;
        col_r[s] <= '0;
      end
      flg_r <= '0;
      cnt_r <= '0;
      fwd_r <= '0;
    end else if (acc) begin
      for (int s = 0; s < WIN - 1; s++) begin
        rng_r[s] <= rng_r[s+1];
        x_r[s]   <= x_r[s+1];
        y_r[s]   <= y_r[s+1];
        z_r[s]   <= z_r[s+1];
        col_r[s] <= col_r[s+1];
      end
      rng_r[WIN-1] <= in_range;
      x_r[WIN-1]   <= in_x;
      y_r[WIN-1]   <= in_y;
      z_r[WIN-1]   <= in_z;
      col_r[WIN-1] <= in_col;
      flg_r        <= flg_nxt;
      fwd_r        <= fwd_nxt;
      if (!last_in) cnt_r <= cnt_r + 1'b1;
    end
  end

  // neighbour sums around the center slot (only H or H+1 can be valid)
  always_comb begin
    logic sel;
    sel = (slot_r != SLW'(H));
    dr = '0;
    dx = '0;
    dy = '0;
    dz = '0;
    for (int k = 0; k <= 2*H; k++) begin
      if (k == H) begin
        dr = dr - SW'(2*H) * $signed({{(SW-18){1'b0}}, rng_r[k + sel]});
        dx = dx - SW'(2*H) * SW'(x_r[k + sel]);
        dy = dy - SW'(2*H) * SW'(y_r[k + sel]);
        dz = dz - SW'(2*H) * SW'(z_r[k + sel]);
      end else begin
        dr = dr + $signed({{(SW-18){1'b0}}, rng_r[k + sel]});
        dx = dx + SW'(x_r[k + sel]);
        dy = dy + SW'(y_r[k + sel]);
        dz = dz + SW'(z_r[k + sel]);
      end
    end
  end

  assign idx_w     = {1'b0, p_r} + (PW+1)'(slot_r) - (PW+1)'(WIN - 1);
  assign idx_ext   = {15'b0, idx_w};
  assign rec_valid = ((slot_r == SLW'(H)) || (slot_r == SLW'(H + 1))) &&
                     (idx_w >= (PW+1)'(H));
  assign rec_last  = last_r && (slot_r == SLW'(WIN - 1));

  assign q_wr.push = push;
  assign q_data    = {dz, dy, dx, dr, rec_last, flg_r[slot_r[SLW-2:0]],
                      rec_valid, idx_ext[15:0]};
endmodule

/* sv/lcom_back.sv */
// Back end: squares, weighted blend, rounding and saturation of curvature.
// Depends on lcom_pkg.
module lcom_back #(
  parameter int unsigned SW = 24,
  parameter int unsigned RW = 115
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lcom_pkg::q_stat_t   q_stat,
  input  logic [RW-1:0]       q_data,
  output logic                q_pop,
  input  logic [16:0]         weight,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_idx,
  output logic [46:0]         out_curv,
  output logic                out_cvalid,
  output logic                out_excl,
  output logic                out_last
);
  localparam int unsigned MW   = SW - 1;
  localparam int unsigned QW   = 2*MW;
  localparam int unsigned AW   = QW + 21;
  localparam int unsigned RESW = AW - 16;

  function automatic logic [MW-1:0] mag(input logic signed [SW-1:0] v);
    logic [SW-1:0] a;
    a = v[SW-1] ? SW'(-v) : SW'(v);
    return a[MW-1:0];
  endfunction

  logic en;
  logic v1_r, v2_r, ov_r;
  logic [18:0] m1_r, m2_r;
  logic [QW-1:0] r2_r, x2_r, y2_r, z2_r;
  logic [QW+16:0] pr_r;
  logic [QW+18:0] px_r;
  logic [16:0] wc, ow;
  logic [AW-1:0] acc;
  logic [RESW-1:0] res;
  logic signed [SW-1:0] dr, dx, dy, dz;
  logic [46:0] curv_r;
  logic [18:0] om_r;

  assign en    = !ov_r || out_ready;
  assign q_pop = en && !q_stat.empty;
  assign {dz, dy, dx, dr} = q_data[RW-1:19];
  assign wc    = (weight > lcom_pkg::WEIGHT_ONE) ? lcom_pkg::WEIGHT_ONE : weight;
  assign ow    = lcom_pkg::WEIGHT_ONE - wc;
  assign acc   = AW'(pr_r) + AW'(px_r) + AW'(32768);
  assign res   = acc[AW-1:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      v1_r <= !q_stat.empty;
      v2_r <= v1_r;
      ov_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r <= q_data[18:0];
      r2_r <= QW'(mag(dr)) * QW'(mag(dr));
      x2_r <= QW'(mag(dx)) * QW'(mag(dx));
      y2_r <= QW'(mag(dy)) * QW'(mag(dy));
      z2_r <= QW'(mag(dz)) * QW'(mag(dz));
      m2_r <= m1_r;
      pr_r <= (QW+17)'(wc) * (QW+17)'(r2_r);
      px_r <= (QW+19)'(ow) * ((QW+19)'(x2_r) + (QW+19)'(y2_r) + (QW+19)'(z2_r));
      om_r <= m2_r;
      if (!m2_r[16]) begin
        curv_r <= '0;
      end else if ((res >> 47) != '0) begin
        curv_r <= '1;
      end else begin
        curv_r <= res[46:0];
      end
    end
  end

  assign out_valid  = ov_r;
  assign out_idx    = om_r[15:0];
  assign out_cvalid = om_r[16];
  assign out_excl   = om_r[17];
  assign out_last   = om_r[18];
  assign out_curv   = curv_r;
endmodule

/* sv/lidar_curvature_occlusion_marker.sv */
// Lidar curvature / occlusion marker top level with config registers; needs lcom_pkg, lcom_front,
// lcom_fifo and lcom_back. out_tvalid rises once a point's result has passed the emit state,
// the queue and then 3 back-end stages behind the queue, when nothing stalls.
// The front end accepts a point only while its emit sequencer is idle, then releases that point's
// results one per cycle while the queue is not full; early in a scan a point releases none.
// Reset: rst_n sync active low; clears window, counters, queue; range_weight=65536, gap=307.
module lidar_curvature_occlusion_marker #(
  parameter int unsigned HALF_WINDOW = 5,
  parameter int unsigned MAX_POINTS  = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  // point input transfer
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // point_range[17:0], coord_x, coord_y, coord_z, column, pad
  input  logic        in_tlast,   // last_point
  // result transfer
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // point_index[15:0], curvature[62:16], curvature_valid,
                                  // excluded, pad
  output logic        out_tlast,  // last_result
  // config port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  // sum width: 18-bit sample, 2H terms plus the 2H-weighted center
  localparam int unsigned SW    = 18 + $clog2(2*HALF_WINDOW) + 2;
  localparam int unsigned RW    = 19 + 4*SW;
  localparam int unsigned DEPTH = 4;

  logic [16:0] weight_r;
  logic [15:0] gap_r;
  logic        cfg_wr;

  lcom_pkg::q_wr_t   q_wr;
  lcom_pkg::q_stat_t q_stat;
  logic [RW-1:0]     q_wdata, q_rdata;
  logic              q_pop;
  logic [15:0]       o_idx;
  logic [46:0]       o_curv;
  logic              o_cvalid, o_excl;

  // registers: range_weight at 0x0, occlusion_gap at 0x4
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= lcom_pkg::WEIGHT_RST;
      gap_r    <= lcom_pkg::GAP_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        lcom_pkg::REG_RANGE_WEIGHT:  weight_r <= cfg_pwdata[16:0];
        lcom_pkg::REG_OCCLUSION_GAP: gap_r    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      lcom_pkg::REG_RANGE_WEIGHT:  cfg_prdata = {15'b0, weight_r};
      lcom_pkg::REG_OCCLUSION_GAP: cfg_prdata = {16'b0, gap_r};
      default:                     cfg_prdata = '0;
    endcase
  end

  // front: window shift + marking, then one queue record per result
  lcom_front #(
    .HALF_WINDOW (HALF_WINDOW),
    .MAX_POINTS  (MAX_POINTS),
    .SW          (SW),
    .RW          (RW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_range (in_tdata[17:0]),
    .in_x     (in_tdata[35:18]),
    .in_y     (in_tdata[53:36]),
    .in_z     (in_tdata[71:54]),
    .in_col   (in_tdata[83:72]),
    .in_last  (in_tlast),
    .gap      (gap_r),
    .q_wr     (q_wr),
    .q_data   (q_wdata),
    .q_stat   (q_stat)
  );

  lcom_fifo #(
    .DW    (RW),
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // back: squares -> weighted blend -> round/saturate, output register
  lcom_back #(
    .SW (SW),
    .RW (RW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .weight     (weight_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_idx    (o_idx),
    .out_curv   (o_curv),
    .out_cvalid (o_cvalid),
    .out_excl   (o_excl),
    .out_last   (out_tlast)
  );

  assign out_tdata = {7'b0, o_excl, o_cvalid, o_curv, o_idx};
endmodule
